### hw/rtl/crl_pkg.sv
// Package for the CSR column lookup: field widths, codes, state encoding and shared types.
`default_nettype none

package crl_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned PTR_W   = 17;
  localparam int unsigned ROW_W   = 11;
  localparam int unsigned COL_W   = 11;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned S_DATA_W = 56;
  localparam int unsigned M_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_WR_ROWPTR = 2'd0,
    OP_WR_COLUMN = 2'd1,
    OP_LOOKUP    = 2'd2,
    OP_UNUSED    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW_LO,
    S_ROW_HI,
    S_BOUNDS,
    S_PROBE,
    S_COMPARE,
    S_DONE
  } search_state_e;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } result_t;

endpackage : crl_pkg

`default_nettype wire

### hw/rtl/crl_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module crl_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 11,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule : crl_ram

`default_nettype wire

### hw/rtl/crl_search.sv
// Lookup sequencer: fetches the row bounds, then binary-searches the column table.
`default_nettype none

module crl_search #(
  parameter int unsigned MAX_ROWS     = 1024,
  parameter int unsigned MAX_NONZEROS = 65536,
  parameter int unsigned RIDX_W       = $clog2(MAX_ROWS + 1),
  parameter int unsigned CIDX_W       = $clog2(MAX_NONZEROS)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [crl_pkg::ROW_W-1:0]   query_row_i,
  input  wire logic [crl_pkg::COL_W-1:0]   query_col_i,
  output logic                             busy_o,
  output logic      [RIDX_W-1:0]           rp_raddr_o,
  input  wire logic [crl_pkg::PTR_W-1:0]   rp_rdata_i,
  output logic      [CIDX_W-1:0]           ci_raddr_o,
  input  wire logic [crl_pkg::COL_W-1:0]   ci_rdata_i,
  output logic                             done_o,
  output crl_pkg::result_t                 result_o,
  input  wire logic                        ack_i
);

  localparam logic [31:0] MAX_ROWS_W = 32'(MAX_ROWS);
  localparam logic [31:0] MAX_NZ_W   = 32'(MAX_NONZEROS);

  crl_pkg::search_state_e state_q, state_d;

  logic [crl_pkg::ROW_W-1:0] row_q;
  logic [crl_pkg::COL_W-1:0] col_q;
  logic [crl_pkg::PTR_W-1:0] lo_q;
  logic [crl_pkg::PTR_W-1:0] start_q, end_q, probe_q;
  logic                      found_q;
  logic [crl_pkg::POS_W-1:0] pos_q;

  // row range check on the incoming query
  logic row_ok;
  assign row_ok = (query_row_i != '0) && ({21'b0, query_row_i} <= MAX_ROWS_W);

  // address conversions, valid for any memory depth
  logic [crl_pkg::ROW_W-1:0]        row_m1;
  logic [RIDX_W+crl_pkg::ROW_W-1:0] row_ext, row_m1_ext;
  logic [CIDX_W+crl_pkg::PTR_W-1:0] probe_ext;
  assign row_m1     = row_q - crl_pkg::ROW_W'(1);
  assign row_ext    = {{RIDX_W{1'b0}}, row_q};
  assign row_m1_ext = {{RIDX_W{1'b0}}, row_m1};
  assign probe_ext  = {{CIDX_W{1'b0}}, probe_q};

  // span from the row bounds; hi arrives on the read port in S_BOUNDS
  logic [crl_pkg::PTR_W-1:0] b_start, b_end_raw, b_end, b_mid;
  logic                      bounds_ok;
  always_comb begin
    b_start   = lo_q - crl_pkg::PTR_W'(1);
    b_end_raw = rp_rdata_i - crl_pkg::PTR_W'(1);
    b_end     = ({15'b0, b_end_raw} > MAX_NZ_W) ? MAX_NZ_W[crl_pkg::PTR_W-1:0] : b_end_raw;
    bounds_ok = (lo_q != '0) && (rp_rdata_i > lo_q) && (b_start < b_end);
    b_mid     = b_start + ((b_end - b_start) >> 1);
  end

  // one probe step
  logic                      hit, stop;
  logic [crl_pkg::PTR_W-1:0] n_start, n_end, n_mid;
  always_comb begin
    hit     = (ci_rdata_i == col_q);
    n_start = (ci_rdata_i < col_q) ? probe_q : start_q;
    n_end   = (ci_rdata_i < col_q) ? end_q : probe_q;
    n_mid   = n_start + ((n_end - n_start) >> 1);
    stop    = (n_mid == probe_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      crl_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = row_ok ? crl_pkg::S_ROW_LO : crl_pkg::S_DONE;
        end
      end
      crl_pkg::S_ROW_LO: state_d = crl_pkg::S_ROW_HI;
      crl_pkg::S_ROW_HI: state_d = crl_pkg::S_BOUNDS;
      crl_pkg::S_BOUNDS: state_d = bounds_ok ? crl_pkg::S_PROBE : crl_pkg::S_DONE;
      crl_pkg::S_PROBE:  state_d = crl_pkg::S_COMPARE;
      crl_pkg::S_COMPARE: begin
        state_d = (hit || stop) ? crl_pkg::S_DONE : crl_pkg::S_PROBE;
      end
      crl_pkg::S_DONE: begin
        if (ack_i) begin
          state_d = crl_pkg::S_IDLE;
        end
      end
      default: state_d = crl_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rp_raddr_o = row_ext[RIDX_W-1:0];
    ci_raddr_o = probe_ext[CIDX_W-1:0];
    busy_o     = 1'b1;
    done_o     = 1'b0;
    case (state_q)
      crl_pkg::S_IDLE:   busy_o = 1'b0;
      crl_pkg::S_ROW_LO: rp_raddr_o = row_m1_ext[RIDX_W-1:0];
      crl_pkg::S_DONE:   done_o = 1'b1;
      default: begin
        rp_raddr_o = row_ext[RIDX_W-1:0];
      end
    endcase
  end

  assign result_o.found    = found_q;
  assign result_o.position = pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      crl_pkg::S_IDLE: begin
        if (start_i) begin
          row_q   <= query_row_i;
          col_q   <= query_col_i;
          found_q <= 1'b0;
          pos_q   <= '0;
        end
      end
      crl_pkg::S_ROW_HI: lo_q <= rp_rdata_i;
      crl_pkg::S_BOUNDS: begin
        start_q <= b_start;
        end_q   <= b_end;
        probe_q <= b_mid;
      end
      crl_pkg::S_COMPARE: begin
        if (hit) begin
          found_q <= 1'b1;
          pos_q   <= probe_q[crl_pkg::POS_W-1:0];
        end
        start_q <= n_start;
        end_q   <= n_end;
        probe_q <= n_mid;
      end
      default: ;
    endcase
  end

endmodule : crl_search

`default_nettype wire

### hw/rtl/csr_column_lookup_core.sv
// CSR column lookup core: table loads, binary-search lookup and the result register.
// Timing: a table write is written into its RAM on the clock edge that accepts it; a lookup
//   reaches the result register after the two row-bound reads and P column probes (17 at worst),
//   or with no table reads for a row off the table.
// Throughput: a table write every cycle while no lookup is running; a lookup holds off the next
//   request until its result moves into the result register, so also while that register stays full.
// Reset (rst_ni, async, low): clears the sequencer and the output valid; tables are not cleared.
`default_nettype none

module csr_column_lookup_core #(
  parameter int unsigned MAX_ROWS     = 1024,
  parameter int unsigned MAX_NONZEROS = 65536
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // request stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] table_index, [32:16] write_value, [43:33] query_row, [54:44] query_col, [55] zero
  input  wire logic [crl_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // [1:0] operation
  input  wire logic [crl_pkg::OP_W-1:0]       s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [15:0] position
  output logic      [crl_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // [0] found
  output logic      [0:0]                     m_axis_tuser
);

  localparam int unsigned RIDX_W = $clog2(MAX_ROWS + 1);
  localparam int unsigned CIDX_W = $clog2(MAX_NONZEROS);
  localparam logic [31:0] MAX_ROWS_W = 32'(MAX_ROWS);
  localparam logic [31:0] MAX_NZ_W   = 32'(MAX_NONZEROS);

  // request fields
  crl_pkg::op_e              req_op;
  logic [crl_pkg::IDX_W-1:0] req_idx;
  logic [crl_pkg::PTR_W-1:0] req_val;
  logic [crl_pkg::ROW_W-1:0] req_row;
  logic [crl_pkg::COL_W-1:0] req_col;
  assign req_op  = crl_pkg::op_e'(s_axis_tuser);
  assign req_idx = s_axis_tdata[15:0];
  assign req_val = s_axis_tdata[32:16];
  assign req_row = s_axis_tdata[43:33];
  assign req_col = s_axis_tdata[54:44];

  logic busy, req_fire;
  assign s_axis_tready = !busy;
  assign req_fire      = s_axis_tvalid && s_axis_tready;

  // table writes go straight to the RAMs; indices past the table are dropped
  logic                               rp_we, ci_we, lookup_start;
  logic [RIDX_W+crl_pkg::IDX_W-1:0]   rp_waddr_ext;
  logic [CIDX_W+crl_pkg::IDX_W-1:0]   ci_waddr_ext;
  assign rp_we = req_fire && (req_op == crl_pkg::OP_WR_ROWPTR)
                 && ({16'b0, req_idx} <= MAX_ROWS_W);
  assign ci_we = req_fire && (req_op == crl_pkg::OP_WR_COLUMN)
                 && ({16'b0, req_idx} < MAX_NZ_W);
  assign lookup_start = req_fire && (req_op == crl_pkg::OP_LOOKUP);
  assign rp_waddr_ext = {{RIDX_W{1'b0}}, req_idx};
  assign ci_waddr_ext = {{CIDX_W{1'b0}}, req_idx};

  logic [RIDX_W-1:0]         rp_raddr;
  logic [crl_pkg::PTR_W-1:0] rp_rdata;
  logic [CIDX_W-1:0]         ci_raddr;
  logic [crl_pkg::COL_W-1:0] ci_rdata;

  // row start pointers, 1-based
  crl_ram #(
    .DEPTH (MAX_ROWS + 1),
    .WIDTH (crl_pkg::PTR_W),
    .AW    (RIDX_W)
  ) u_row_ptr (
    .clk_i   (clk_i),
    .we_i    (rp_we),
    .waddr_i (rp_waddr_ext[RIDX_W-1:0]),
    .wdata_i (req_val),
    .raddr_i (rp_raddr),
    .rdata_o (rp_rdata)
  );

  // column numbers, low 11 bits of the written value
  crl_ram #(
    .DEPTH (MAX_NONZEROS),
    .WIDTH (crl_pkg::COL_W),
    .AW    (CIDX_W)
  ) u_col_idx (
    .clk_i   (clk_i),
    .we_i    (ci_we),
    .waddr_i (ci_waddr_ext[CIDX_W-1:0]),
    .wdata_i (req_val[crl_pkg::COL_W-1:0]),
    .raddr_i (ci_raddr),
    .rdata_o (ci_rdata)
  );

  logic             srch_done, srch_ack;
  crl_pkg::result_t srch_res;

  crl_search #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_NONZEROS (MAX_NONZEROS),
    .RIDX_W       (RIDX_W),
    .CIDX_W       (CIDX_W)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (lookup_start),
    .query_row_i (req_row),
    .query_col_i (req_col),
    .busy_o      (busy),
    .rp_raddr_o  (rp_raddr),
    .rp_rdata_i  (rp_rdata),
    .ci_raddr_o  (ci_raddr),
    .ci_rdata_i  (ci_rdata),
    .done_o      (srch_done),
    .result_o    (srch_res),
    .ack_i       (srch_ack)
  );

  // output register: frees the sequencer while a result waits downstream
  logic             m_valid_q, m_valid_d;
  crl_pkg::result_t m_res_q;

  assign srch_ack = srch_done && (!m_valid_q || m_axis_tready);

  always_comb begin
    m_valid_d = m_valid_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (srch_ack) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (srch_ack) begin
      m_res_q <= srch_res;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_res_q.position;
  assign m_axis_tuser[0] = m_res_q.found;

endmodule : csr_column_lookup_core

`default_nettype wire
